// ----- hw/rtl/tlwl_pkg.sv -----
package tlwl_pkg;

  localparam int MAX_WINDOWS = 4096;
  localparam int ADDR_W      = $clog2(MAX_WINDOWS);
  localparam int CNT_W       = 13;
  localparam int ID_W        = 32;
  localparam int REQ_W       = 2;
  localparam int DIV_W       = CNT_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int FIRST_W     = 2 * CNT_W;
  localparam int STATE_W     = 4;

  localparam logic [REQ_W-1:0] REQ_LOAD_WIN   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_SUPER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOCATE     = 2'd2;

  localparam logic CFG_GROUP_SIZE   = 1'b0;
  localparam logic CFG_WINDOW_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_WINDOWS);

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] index;
    logic [ID_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] window_index;
  } res_t;

  // effective settings: group size at least 1, window count saturated
  typedef struct packed {
    logic [CNT_W-1:0] group;
    logic [CNT_W-1:0] count;
  } cfg_t;

endpackage

// ----- hw/rtl/tlwl_ram.sv -----
module tlwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tlwl_div.sv -----
// restoring divider, one quotient bit per cycle
module tlwl_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tlwl_pkg::DIV_W-1:0]   num,
  input  logic [tlwl_pkg::CNT_W-1:0]   den,
  output logic                         busy,
  output logic [tlwl_pkg::DIV_W-1:0]   quot
);
  import tlwl_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W-1:0]     rem;
  logic [DIV_W-1:0]     rem_sh;
  logic [DIV_W-1:0]     diff;
  logic                 take;

  assign rem_sh = {rem, quot[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign take   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      rem  <= take ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quot <= {quot[DIV_W-2:0], take};
    end
  end

endmodule

// ----- hw/rtl/tlwl_seq.sv -----
module tlwl_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tlwl_pkg::req_t req,
  input  tlwl_pkg::cfg_t cfg,
  input  logic          out_free,
  output logic          idle,
  output logic          done,
  output tlwl_pkg::res_t res
);
  import tlwl_pkg::*;

  localparam logic [STATE_W-1:0] S_IDLE = 4'd0;
  localparam logic [STATE_W-1:0] S_LOAD = 4'd1;
  localparam logic [STATE_W-1:0] S_TAIL = 4'd2;
  localparam logic [STATE_W-1:0] S_TCMP = 4'd3;
  localparam logic [STATE_W-1:0] S_DIVW = 4'd4;
  localparam logic [STATE_W-1:0] S_BCHK = 4'd5;
  localparam logic [STATE_W-1:0] S_BCMP = 4'd6;
  localparam logic [STATE_W-1:0] S_SSET = 4'd7;
  localparam logic [STATE_W-1:0] S_SCHK = 4'd8;
  localparam logic [STATE_W-1:0] S_SCMP = 4'd9;
  localparam logic [STATE_W-1:0] S_DONE = 4'd10;

  logic [STATE_W-1:0] state, state_next;
  req_t               cur;
  logic [CNT_W-1:0]   lo, hi, mid, last;
  logic [FIRST_W-1:0] first, pos;
  logic [CNT_W:0]     mid_sum;
  logic [FIRST_W:0]   last_sum;

  logic               win_we, sup_we;
  logic [ADDR_W-1:0]  win_raddr, sup_raddr;
  logic [ID_W-1:0]    win_rdata, sup_rdata, cmp_data;
  logic               below;

  logic               div_start, div_busy;
  logic [DIV_W-1:0]   div_num, div_quot;

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE) && out_free;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CNT_W:1];
  assign last_sum = {1'b0, first} + (FIRST_W + 1)'(cfg.group);

  // the one shared comparator: stored id below the query
  assign cmp_data = (state == S_BCMP) ? sup_rdata : win_rdata;
  assign below    = cmp_data < cur.value;

  assign win_we    = (state == S_LOAD) && (cur.kind == REQ_LOAD_WIN);
  assign sup_we    = (state == S_LOAD) && (cur.kind == REQ_LOAD_SUPER);
  assign win_raddr = (state == S_TAIL) ? ADDR_W'(cfg.count - 1'b1) : pos[ADDR_W-1:0];
  assign sup_raddr = mid[ADDR_W-1:0];

  assign div_start = (state == S_TAIL) && (cfg.count != '0);
  assign div_num   = {1'b0, cfg.count} + {1'b0, cfg.group} - 1'b1;

  tlwl_ram #(.WIDTH(ID_W), .DEPTH(MAX_WINDOWS)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (cur.index),
    .wdata (cur.value),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  tlwl_ram #(.WIDTH(ID_W), .DEPTH(MAX_WINDOWS)) u_sup_ram (
    .clk   (clk),
    .we    (sup_we),
    .waddr (cur.index),
    .wdata (cur.value),
    .raddr (sup_raddr),
    .rdata (sup_rdata)
  );

  tlwl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cfg.group),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req.kind)
            REQ_LOAD_WIN, REQ_LOAD_SUPER: state_next = S_LOAD;
            REQ_LOCATE:                   state_next = S_TAIL;
            default:                      state_next = S_DONE;
          endcase
        end
      end
      S_LOAD: state_next = S_DONE;
      S_TAIL: state_next = (cfg.count == '0) ? S_DONE : S_TCMP;
      S_TCMP: state_next = below ? S_DONE : S_DIVW;
      S_DIVW: state_next = div_busy ? S_DIVW : S_BCHK;
      S_BCHK: state_next = (lo < hi) ? S_BCMP : S_SSET;
      S_BCMP: state_next = S_BCHK;
      S_SSET: state_next = S_SCHK;
      S_SCHK: state_next = (pos < FIRST_W'(last)) ? S_SCMP : S_DONE;
      S_SCMP: state_next = below ? S_SCHK : S_DONE;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= req;
        res <= '0;
      end
      S_DIVW: begin
        lo <= '0;
        hi <= div_quot[CNT_W-1:0];
      end
      S_BCHK: begin
        first <= lo * cfg.group;
      end
      S_BCMP: begin
        if (below) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      S_SSET: begin
        pos  <= first;
        last <= (last_sum > (FIRST_W + 1)'(cfg.count)) ? cfg.count : last_sum[CNT_W-1:0];
      end
      S_SCMP: begin
        if (below) begin
          pos <= pos + 1'b1;
        end else begin
          res.found        <= 1'b1;
          res.window_index <= pos[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/two_level_window_locator_top.sv -----
// Load words write one table entry and return an empty result; locate runs a tail
// check and the super-block count divider, then a binary search over the super-blocks
// and a scan of the windows in one group, all through one RAM read
// port per table and one shared 32-bit compare. One word at a time.
// Reset (rst, synchronous) restores a group length of 1 and window_count 0; table
// contents are undefined until written.
module two_level_window_locator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // entry_index[11:0], doc_value[43:12], zero pad
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // window_index[11:0], zero pad
  output logic [0:0]  m_tuser,   // found[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import tlwl_pkg::*;

  logic [CNT_W-1:0] grp_len, window_count;
  cfg_t             cfg;
  req_t             req;
  res_t             res;
  logic             idle, done, out_free, start;

  assign cfg_ready = 1'b1;
  assign cfg.group = (grp_len == '0) ? CNT_W'(1) : grp_len;
  assign cfg.count = (window_count > MAX_COUNT) ? MAX_COUNT : window_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_len      <= CNT_W'(1);
      window_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GROUP_SIZE:   grp_len      <= cfg_data;
        CFG_WINDOW_COUNT: window_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready  = idle;
  assign start     = s_tvalid && s_tready;
  assign req.kind  = s_tuser;
  assign req.index = s_tdata[ADDR_W-1:0];
  assign req.value = s_tdata[ADDR_W +: ID_W];
  assign out_free  = !m_tvalid || m_tready;

  tlwl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .cfg      (cfg),
    .out_free (out_free),
    .idle     (idle),
    .done     (done),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {4'b0, res.window_index};
      m_tuser <= res.found;
    end
  end

endmodule

// ----- tb/sv/two_level_window_locator_top_test.sv -----
module two_level_window_locator_top_test;
  import tlwl_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned IDLE_LIMIT   = 40000;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_REPORTS  = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [47:0]       s_tdata = '0;    // entry_index[11:0], doc_value[43:12], zero pad
  logic [1:0]        s_tuser = '0;    // req_type[1:0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;         // window_index[11:0], zero pad
  logic [0:0]        m_tuser;         // found[0]
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [CNT_W-1:0]  cfg_data = '0;

  // lookup tables and settings as the block should hold them
  bit [ID_W-1:0]     win_ids [MAX_WINDOWS];
  bit [ID_W-1:0]     sup_ids [MAX_WINDOWS];
  logic [CNT_W-1:0]  group_cfg;
  logic [CNT_W-1:0]  count_cfg;
  // window ids in the order the stimulus laid them down
  bit [ID_W-1:0]     plan_win [MAX_WINDOWS];

  req_t              req_backlog [$];
  res_t              pending_results [$];

  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned stall_cycles = 0;

  int unsigned words_in = 0;
  int unsigned results_seen = 0;
  int unsigned n_locates = 0;
  int unsigned n_found = 0;
  int unsigned settings = 0;
  int unsigned queued = 0;
  int unsigned errors = 0;

  two_level_window_locator_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic res_t predict_locate(input logic [ID_W-1:0] q);
    int unsigned g, n, n_sup, lo, hi, mid, scan_lo, scan_hi;
    res_t r;
    r = '0;
    g = (group_cfg == 0) ? 1 : group_cfg;
    n = (count_cfg > MAX_COUNT) ? MAX_WINDOWS : count_cfg;
    if (n == 0 || q > win_ids[n-1]) return r;
    n_sup = (n + g - 1) / g;
    lo = 0;
    hi = n_sup;
    // lower bound over super-block last ids
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (sup_ids[mid] < q) lo = mid + 1;
      else hi = mid;
    end
    scan_lo = lo * g;
    scan_hi = (scan_lo + g > n) ? n : scan_lo + g;
    for (int unsigned i = scan_lo; i < scan_hi; i++) begin
      if (q <= win_ids[i]) begin
        r.found = 1'b1;
        r.window_index = ADDR_W'(i);
        return r;
      end
    end
    return r;
  endfunction

  function automatic res_t apply_request(input req_t w);
    res_t r;
    r = '0;
    case (w.kind)
      REQ_LOAD_WIN:   win_ids[w.index] = w.value;
      REQ_LOAD_SUPER: sup_ids[w.index] = w.value;
      REQ_LOCATE: begin
        r = predict_locate(w.value);
        n_locates++;
        if (r.found) n_found++;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      group_cfg <= 13'd1;
      count_cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_GROUP_SIZE) group_cfg <= cfg_data;
      else count_cfg <= cfg_data;
    end
  end

  always @(posedge clk) begin : drive_requests
    req_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        w.kind  = s_tuser;
        w.index = s_tdata[ADDR_W-1:0];
        w.value = s_tdata[ADDR_W +: ID_W];
        pending_results = {pending_results, apply_request(w)};
        words_in++;
      end
      if ($urandom_range(0, 63) == 0) tx_quiet <= !tx_quiet;
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          s_tvalid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (req_backlog.size() != 0) begin
          w = req_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= w.kind;
          s_tdata <= {4'b0, w.value, w.index};
          tx_gap <= pick_gap(tx_quiet);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    int unsigned gap;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result word with nothing pending: found=%0b index=%0d",
                     $time, m_tuser[0], m_tdata[ADDR_W-1:0]);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser[0] !== want.found) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: found mismatch: expected %0b, got %0b",
                       $time, want.found, m_tuser[0]);
          end
          if (m_tdata[ADDR_W-1:0] !== want.window_index) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: window_index mismatch: expected %0d, got %0d",
                       $time, want.window_index, m_tdata[ADDR_W-1:0]);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) rx_quiet <= !rx_quiet;
      // one long hold-off so the block backs up into its input
      if (results_seen >= HOLD_AT && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        gap = pick_gap(rx_quiet);
        rx_gap <= gap;
        m_tready <= (gap == 0);
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= (rx_gap == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] slot,
                          input logic [ID_W-1:0] id);
    req_t w;
    w.kind = kind;
    w.index = slot;
    w.value = id;
    if (kind == REQ_LOAD_WIN) plan_win[slot] = id;
    req_backlog = {req_backlog, w};
    queued++;
  endtask

  // sampled on the falling edge so all rising-edge updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || s_tvalid || !s_tready || m_tvalid ||
           pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [ID_W-1:0] pick_query(input int unsigned n);
    int unsigned i;
    i = (n == 0) ? 0 : $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      3, 4:    return plan_win[i] - 1;
      5, 6:    return plan_win[i] + 1;
      default: return plan_win[i];
    endcase
  endfunction

  // Windows [win_from, n) get non-decreasing ids, super-blocks get the last id of
  // their group; now and then the tables are deliberately scrambled.
  task automatic run_phase(input logic [CNT_W-1:0] g_raw, input logic [CNT_W-1:0] n_raw,
                           input int unsigned win_from, input int unsigned n_ops);
    int unsigned g, n, n_sup, span, step, sb_end, k;
    logic [ID_W-1:0] id;
    bit broken;
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_GROUP_SIZE, g_raw);
      write_reg(CFG_WINDOW_COUNT, n_raw);
    end else begin
      write_reg(CFG_WINDOW_COUNT, n_raw);
      write_reg(CFG_GROUP_SIZE, g_raw);
    end
    g = (g_raw == 0) ? 1 : g_raw;
    n = (n_raw > MAX_COUNT) ? MAX_WINDOWS : n_raw;
    n_sup = (n + g - 1) / g;
    broken = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 3))
      0:       span = 1;
      1:       span = 64;
      2:       span = 1 << 20;
      default: span = (n == 0) ? 1 : 32'hFFFF_FFFF / n;
    endcase
    if (win_from == 0) id = $urandom_range(0, 1) ? '0 : $urandom_range(0, span);
    else id = plan_win[win_from - 1];
    for (k = win_from; k < n; k++) begin
      if (broken && $urandom_range(0, 3) == 0) begin
        push_req(REQ_LOAD_WIN, ADDR_W'(k), $urandom());
      end else begin
        step = $urandom_range(0, span);
        id = (id > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : id + step;
        push_req(REQ_LOAD_WIN, ADDR_W'(k), id);
      end
    end
    for (k = 0; k < n_sup; k++) begin
      sb_end = (k * g + g > n) ? n : k * g + g;
      if (broken && $urandom_range(0, 2) == 0) push_req(REQ_LOAD_SUPER, ADDR_W'(k), $urandom());
      else push_req(REQ_LOAD_SUPER, ADDR_W'(k), plan_win[sb_end - 1]);
    end
    for (k = 0; k < n_ops; k++) begin
      case ($urandom_range(0, 19))
        0: push_req(REQ_LOAD_WIN, ADDR_W'($urandom_range(0, MAX_WINDOWS - 1)), $urandom());
        1: push_req(REQ_LOAD_SUPER, ADDR_W'($urandom_range(0, MAX_WINDOWS - 1)), $urandom());
        2: push_req(REQ_UNUSED, ADDR_W'($urandom_range(0, MAX_WINDOWS - 1)), $urandom());
        default: push_req(REQ_LOCATE, ADDR_W'($urandom_range(0, MAX_WINDOWS - 1)),
                          pick_query(n));
      endcase
    end
  endtask

  initial begin
    logic [CNT_W-1:0] g_raw, n_raw;
    int unsigned      k;
    logic [ID_W-1:0]  top_id;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no windows, nothing can be found
    push_req(REQ_LOCATE, '0, '0);
    push_req(REQ_LOCATE, '1, '1);
    push_req(REQ_UNUSED, '1, '1);

    // seven windows in groups of three, duplicate ids in window 1 and 2
    wait_idle();
    write_reg(CFG_GROUP_SIZE, 13'd3);
    write_reg(CFG_WINDOW_COUNT, 13'd7);
    push_req(REQ_LOAD_WIN, 12'd0, 32'd10);
    push_req(REQ_LOAD_WIN, 12'd1, 32'd20);
    push_req(REQ_LOAD_WIN, 12'd2, 32'd20);
    push_req(REQ_LOAD_WIN, 12'd3, 32'd35);
    push_req(REQ_LOAD_WIN, 12'd4, 32'd50);
    push_req(REQ_LOAD_WIN, 12'd5, 32'd60);
    push_req(REQ_LOAD_WIN, 12'd6, 32'hFFFF_FFF0);
    push_req(REQ_LOAD_SUPER, 12'd0, 32'd20);
    push_req(REQ_LOAD_SUPER, 12'd1, 32'd60);
    push_req(REQ_LOAD_SUPER, 12'd2, 32'hFFFF_FFF0);
    push_req(REQ_LOCATE, 12'd0, 32'd0);
    push_req(REQ_LOCATE, 12'd0, 32'd10);
    push_req(REQ_LOCATE, 12'd0, 32'd11);
    push_req(REQ_LOCATE, 12'd0, 32'd21);
    push_req(REQ_LOCATE, 12'd0, 32'd50);
    push_req(REQ_LOCATE, 12'd0, 32'd51);
    push_req(REQ_LOCATE, 12'd0, 32'hFFFF_FFF0);
    push_req(REQ_LOCATE, 12'd0, '1);
    push_req(REQ_UNUSED, 12'd0, 32'd35);

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       g_raw = '0;
        1:       g_raw = MAX_COUNT;
        2:       g_raw = '1;
        3:       g_raw = CNT_W'($urandom_range(9, 8191));
        default: g_raw = CNT_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       n_raw = '0;
        1:       n_raw = CNT_W'($urandom_range(41, 200));
        default: n_raw = CNT_W'($urandom_range(1, 40));
      endcase
      run_phase(g_raw, n_raw, 0, $urandom_range(20, 60));
    end

    // saturated window count in groups of 64: only the last group holds real
    // ids and every earlier super-block is zero, so nonzero queries land there
    wait_idle();
    write_reg(CFG_GROUP_SIZE, 13'd64);
    write_reg(CFG_WINDOW_COUNT, '1);
    top_id = 32'd1000 + 32'd16 * 32'd63;
    for (k = 0; k < 64; k++) begin
      push_req(REQ_LOAD_WIN, ADDR_W'(MAX_WINDOWS - 64 + k), 32'd1000 + 32'(k * 16));
      push_req(REQ_LOAD_SUPER, ADDR_W'(k), (k == 63) ? top_id : '0);
    end
    push_req(REQ_LOCATE, 12'd0, 32'd1);
    push_req(REQ_LOCATE, 12'd0, 32'd1000);
    push_req(REQ_LOCATE, 12'd0, 32'd1001);
    push_req(REQ_LOCATE, 12'd0, top_id);
    push_req(REQ_LOCATE, 12'd0, top_id + 32'd1);
    push_req(REQ_LOCATE, 12'd0, '1);
    for (k = 0; k < 16; k++) begin
      push_req(REQ_LOCATE, ADDR_W'(k), $urandom_range(1, top_id));
    end

    run_phase(13'd1, '0, 0, 10);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Sent %0d request words, checked %0d result words over %0d register writes",
             words_in, results_seen, settings);
    $display("Locates: %0d, of which %0d landed in a window", n_locates, n_found);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tlwl_pkg.sv
hw/rtl/tlwl_ram.sv
hw/rtl/tlwl_div.sv
hw/rtl/tlwl_seq.sv
hw/rtl/two_level_window_locator_top.sv
tb/sv/two_level_window_locator_top_test.sv
